>>> hw/rtl/filtered_pid_duty_regulator_assert.svh
// Assertion macros for the filtered PID duty regulator.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef FILTERED_PID_DUTY_REGULATOR_ASSERT_SVH
`define FILTERED_PID_DUTY_REGULATOR_ASSERT_SVH

// Property that must hold on every edge outside reset
`define FPID_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Condition in one cycle implies a consequence in the next cycle
`define FPID_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

>>> hw/rtl/fpid_pkg.sv
// Shared constants, types and codes for the filtered PID duty regulator.
// No dependencies; every other file but the assertion header imports this package.
package fpid_pkg;

   // Filter and field widths
   localparam int FILTER_ORDER = 3;
   localparam int TAPS         = FILTER_ORDER + 1;
   localparam int SAMPLE_W     = 12;
   localparam int SUM_W        = SAMPLE_W + $clog2(TAPS);
   localparam int FILT_SHIFT   = 20;
   localparam int FILT_RECIP   = ((1 << FILT_SHIFT) + TAPS - 1) / TAPS;
   localparam int ERR_W        = 13;
   localparam int DIFF_W       = ERR_W + 1;
   localparam int DUTY_W       = 10;
   localparam int DUTY_MAX     = 999;
   localparam int GAIN_W       = 16;
   localparam int PERIOD_W     = 8;
   localparam int ACC_W        = 32;

   // Shared multiplier
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 25;
   localparam int MUL_W   = MUL_A_W + MUL_B_W;

   // Scale factors of the derivative and integral terms
   localparam int D_SCALE  = 256000;
   localparam int TI_SCALE = 1000;
   localparam int E_SHIFT  = 16;
   localparam int I_SHIFT  = 24;

   // Shared divider: magnitude dividend, several quotient bits a cycle
   localparam int DIV_W      = 56;
   localparam int DVSR_W     = 26;
   localparam int DIV_DIGITS = 4;
   localparam int DIV_CYCLES = DIV_W / DIV_DIGITS;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

   // Term sum and final gain product
   localparam int TERM_W     = DIV_W + 1;
   localparam int SSUM_W     = TERM_W + 1;
   localparam int S_W        = 41;
   localparam int S_LO_W     = 24;
   localparam int HI_PROD_W  = S_W - S_LO_W + GAIN_W;

   // Register file
   localparam int NUM_REGS   = 5;
   localparam int CSR_ADDR_W = $clog2(NUM_REGS * 4);
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_SET_POINT       = 3'd0,
      REG_PROP_GAIN       = 3'd1,
      REG_INTEGRAL_TIME   = 3'd2,
      REG_DERIVATIVE_TIME = 3'd3,
      REG_PERIOD_MS       = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] set_point;
      logic [GAIN_W-1:0]   prop_gain;
      logic [GAIN_W-1:0]   integral_time;
      logic [GAIN_W-1:0]   derivative_time;
      logic [PERIOD_W-1:0] period_ms;
   } cfg_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_FILT,
      MUL_ERR_PER,
      MUL_TD_DIFF,
      MUL_SCALE,
      MUL_TI,
      MUL_KP_LO,
      MUL_KP_HI
   } mul_op_type;

   typedef enum logic {
      DIV_DTERM,
      DIV_ITERM
   } div_sel_type;

   typedef struct packed {
      logic        shift;
      logic        sum_en;
      logic        err_en;
      logic        integ_en;
      mul_op_type  mul_op;
      logic        div_start;
      div_sel_type div_sel;
      logic        dterm_en;
      logic        iterm_en;
      logic        s_en;
      logic        plo_en;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_FILT_MUL,
      ST_FILT,
      ST_ERR_MUL,
      ST_INTEG,
      ST_DSCALE,
      ST_DDIV,
      ST_DWAIT,
      ST_IDIV,
      ST_IWAIT,
      ST_SSUM,
      ST_KLO,
      ST_KHI,
      ST_DUTY
   } state_type;

endpackage

>>> hw/rtl/fpid_req_if.sv
// Input channel of the regulator: one raw sample per item.
// Depends on fpid_pkg.
interface fpid_req_if;
   import fpid_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

>>> hw/rtl/fpid_rsp_if.sv
// Result channel of the regulator: duty, filtered level and error per item.
// Depends on fpid_pkg.
interface fpid_rsp_if;
   import fpid_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [DUTY_W-1:0]       duty;
   logic [SAMPLE_W-1:0]     filtered;
   logic signed [ERR_W-1:0] control_error;

   modport source (output valid, output duty, output filtered, output control_error,
                   input ready);
   modport sink (input valid, input duty, input filtered, input control_error,
                 output ready);
endinterface

>>> hw/rtl/fpid_csr.sv
// APB-style register file holding the regulator's gains, times and set point.
// Depends on fpid_pkg.
module fpid_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fpid_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fpid_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [fpid_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output fpid_pkg::cfg_type               cfg
);
   import fpid_pkg::*;

   cfg_type                 cfg_ff;
   cfg_type                 cfg_in;
   logic                    wr_en;
   logic [CSR_ADDR_W-3:0]   reg_idx;

   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // Decode the write; unknown addresses leave everything alone
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SET_POINT:       cfg_in.set_point       = pwdata[SAMPLE_W-1:0];
            REG_PROP_GAIN:       cfg_in.prop_gain       = pwdata[GAIN_W-1:0];
            REG_INTEGRAL_TIME:   cfg_in.integral_time   = pwdata[GAIN_W-1:0];
            REG_DERIVATIVE_TIME: cfg_in.derivative_time = pwdata[GAIN_W-1:0];
            REG_PERIOD_MS:       cfg_in.period_ms       = pwdata[PERIOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_point       <= '0;
         cfg_ff.prop_gain       <= GAIN_W'(256);
         cfg_ff.integral_time   <= GAIN_W'(256);
         cfg_ff.derivative_time <= '0;
         cfg_ff.period_ms       <= PERIOD_W'(10);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         REG_SET_POINT:       prdata = CSR_DATA_W'(cfg_ff.set_point);
         REG_PROP_GAIN:       prdata = CSR_DATA_W'(cfg_ff.prop_gain);
         REG_INTEGRAL_TIME:   prdata = CSR_DATA_W'(cfg_ff.integral_time);
         REG_DERIVATIVE_TIME: prdata = CSR_DATA_W'(cfg_ff.derivative_time);
         REG_PERIOD_MS:       prdata = CSR_DATA_W'(cfg_ff.period_ms);
         default:             prdata = '0;
      endcase
   end

endmodule

>>> hw/rtl/fpid_div.sv
// Iterative unsigned divider, restoring, several quotient bits per cycle.
// Depends on fpid_pkg; used by the datapath for both divided PID terms.
module fpid_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [fpid_pkg::DIV_W-1:0]  dividend,
   input  logic [fpid_pkg::DVSR_W-1:0] divisor,
   output logic                        busy,
   output logic [fpid_pkg::DIV_W-1:0]  quotient
);
   import fpid_pkg::*;

   logic [DVSR_W:0]    rem_ff;
   logic [DVSR_W:0]    rem_in;
   logic [DIV_W-1:0]   quo_ff;
   logic [DIV_W-1:0]   quo_in;
   logic [DVSR_W-1:0]  dvsr_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_CNT_W-1:0] cnt_in;
   logic               busy_ff;
   logic               busy_in;
   logic [DVSR_W:0]    step_rem;
   logic [DIV_W-1:0]   step_quo;

   // Retire a few quotient bits: shift in, compare, subtract
   always_comb begin
      step_rem = rem_ff;
      step_quo = quo_ff;
      for (int i = 0; i < DIV_DIGITS; i++) begin
         step_rem = {step_rem[DVSR_W-1:0], step_quo[DIV_W-1]};
         step_quo = {step_quo[DIV_W-2:0], 1'b0};
         if (step_rem >= {1'b0, dvsr_ff}) begin
            step_rem    = step_rem - {1'b0, dvsr_ff};
            step_quo[0] = 1'b1;
         end
      end
   end

   // Load on start, else advance while busy
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = DIV_CNT_W'(DIV_CYCLES);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = step_rem;
         quo_in  = step_quo;
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvsr_ff <= divisor;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

>>> hw/rtl/fpid_dp.sv
// Datapath: sample line, filter, error, integral, shared multiplier, divider, output register.
// Depends on fpid_pkg and fpid_div; steered by the controller's command struct.
module fpid_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  fpid_pkg::cfg_type                   cfg,
   input  fpid_pkg::cmd_type                   cmd,
   output fpid_pkg::status_type                status,
   input  logic [fpid_pkg::SAMPLE_W-1:0]       sample,
   output logic [fpid_pkg::DUTY_W-1:0]         duty,
   output logic [fpid_pkg::SAMPLE_W-1:0]       filtered,
   output logic signed [fpid_pkg::ERR_W-1:0]   control_error
);
   import fpid_pkg::*;

   localparam logic signed [SSUM_W-1:0] S_LIMIT = SSUM_W'(longint'(1) << (S_W - 1));

   // Model state
   logic [SAMPLE_W-1:0]       taps_ff [TAPS];
   logic signed [ERR_W-1:0]   last_err_ff;
   logic signed [ACC_W-1:0]   integ_ff;
   logic signed [ACC_W-1:0]   integ_in;

   // Working registers
   logic [SUM_W-1:0]          sum_ff;
   logic [SUM_W-1:0]          sum_in;
   logic signed [MUL_W-1:0]   mul_ff;
   logic signed [MUL_W-1:0]   mul_prod;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic [SAMPLE_W-1:0]       filt_ff;
   logic [SAMPLE_W-1:0]       filt_in;
   logic signed [ERR_W-1:0]   err_ff;
   logic signed [ERR_W-1:0]   err_in;
   logic signed [DIFF_W-1:0]  diff_ff;
   logic signed [DIFF_W-1:0]  diff_in;
   logic                      neg_ff;
   logic                      neg_in;
   logic signed [TERM_W-1:0]  dterm_ff;
   logic signed [TERM_W-1:0]  iterm_ff;
   logic signed [TERM_W-1:0]  term_in;
   logic [S_W-1:0]            s_ff;
   logic [S_W-1:0]            s_in;
   logic [GAIN_W-1:0]         plo_ff;
   logic [DUTY_W-1:0]         duty_ff;
   logic [DUTY_W-1:0]         duty_in;
   logic [SAMPLE_W-1:0]       rsp_filt_ff;
   logic signed [ERR_W-1:0]   rsp_err_ff;

   // Effective period and integral time, zero read as one
   logic [PERIOD_W-1:0]       per_eff;
   logic [GAIN_W-1:0]         ti_eff;

   logic signed [ACC_W:0]     acc_sum;
   logic [MUL_W-1:0]          mul_mag;
   logic [ACC_W-1:0]          integ_mag;
   logic [DIV_W-1:0]          div_dividend;
   logic [DVSR_W-1:0]         div_divisor;
   logic                      div_busy;
   logic [DIV_W-1:0]          div_quotient;
   logic signed [SSUM_W-1:0]  e_term;
   logic signed [SSUM_W-1:0]  s_sum;
   logic [HI_PROD_W:0]        q_sum;

   assign per_eff = (cfg.period_ms == '0) ? PERIOD_W'(1) : cfg.period_ms;
   assign ti_eff  = (cfg.integral_time == '0) ? GAIN_W'(1) : cfg.integral_time;

   // Shift the new sample into the delay line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TAPS; k++) begin
            taps_ff[k] <= '0;
         end
      end else if (cmd.shift) begin
         taps_ff[0] <= sample;
         for (int k = 1; k < TAPS; k++) begin
            taps_ff[k] <= taps_ff[k-1];
         end
      end
   end

   // Sum the taps
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < TAPS; k++) begin
         sum_in = sum_in + SUM_W'(taps_ff[k]);
      end
   end

   // Shared multiplier operand steering
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.mul_op)
         MUL_NONE: begin
         end
         MUL_FILT: begin
            mul_a = MUL_A_W'(sum_ff);
            mul_b = MUL_B_W'(FILT_RECIP);
         end
         MUL_ERR_PER: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = MUL_B_W'(per_eff);
         end
         MUL_TD_DIFF: begin
            mul_a = MUL_A_W'(diff_ff);
            mul_b = MUL_B_W'(cfg.derivative_time);
         end
         MUL_SCALE: begin
            mul_a = mul_ff[MUL_A_W-1:0];
            mul_b = MUL_B_W'(D_SCALE);
         end
         MUL_TI: begin
            mul_a = MUL_A_W'(ti_eff);
            mul_b = MUL_B_W'(TI_SCALE);
         end
         MUL_KP_LO: begin
            mul_a = MUL_A_W'(cfg.prop_gain);
            mul_b = MUL_B_W'(s_ff[S_LO_W-1:0]);
         end
         MUL_KP_HI: begin
            mul_a = MUL_A_W'(s_ff[S_W-1:S_LO_W]);
            mul_b = MUL_B_W'(cfg.prop_gain);
         end
         default: begin
         end
      endcase
   end

   assign mul_prod = mul_a * mul_b;

   // Mean of the taps, error against the set point, step of the error
   assign filt_in = mul_ff[FILT_SHIFT+SAMPLE_W-1:FILT_SHIFT];
   assign err_in  = $signed({1'b0, cfg.set_point}) - $signed({1'b0, filt_in});
   assign diff_in = DIFF_W'(err_in) - DIFF_W'(last_err_ff);

   // Integral plus error times period, saturated to the accumulator width
   always_comb begin
      acc_sum = $signed({integ_ff[ACC_W-1], integ_ff}) + $signed(mul_ff[ACC_W:0]);
      if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
         integ_in = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         integ_in = acc_sum[ACC_W-1:0];
      end
   end

   // Divider operands: magnitudes, sign kept aside
   always_comb begin
      mul_mag   = mul_ff[MUL_W-1] ? -mul_ff : mul_ff;
      integ_mag = integ_ff[ACC_W-1] ? -integ_ff : integ_ff;
      unique case (cmd.div_sel)
         DIV_DTERM: begin
            div_dividend = DIV_W'(mul_mag);
            div_divisor  = DVSR_W'(per_eff);
            neg_in       = mul_ff[MUL_W-1];
         end
         DIV_ITERM: begin
            div_dividend = {integ_mag, {I_SHIFT{1'b0}}};
            div_divisor  = mul_ff[DVSR_W-1:0];
            neg_in       = integ_ff[ACC_W-1];
         end
         default: begin
            div_dividend = '0;
            div_divisor  = '0;
            neg_in       = 1'b0;
         end
      endcase
   end

   fpid_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   assign status.div_busy = div_busy;

   // Quotient back to a signed term, truncated toward zero
   assign term_in = neg_ff ? -TERM_W'(div_quotient) : TERM_W'(div_quotient);

   // Sum of the three terms; keep only the positive part, clamped
   always_comb begin
      e_term = SSUM_W'(err_ff) <<< E_SHIFT;
      s_sum  = SSUM_W'(dterm_ff) + SSUM_W'(iterm_ff) + e_term;
      if (s_sum[SSUM_W-1] || (s_sum == '0)) begin
         s_in = '0;
      end else if (s_sum > S_LIMIT) begin
         s_in = S_LIMIT[S_W-1:0];
      end else begin
         s_in = s_sum[S_W-1:0];
      end
   end

   // Gain times sum over two partial products, then clamp the duty
   assign q_sum   = (HI_PROD_W+1)'(mul_ff[HI_PROD_W-1:0]) + (HI_PROD_W+1)'(plo_ff);
   assign duty_in = (q_sum > (HI_PROD_W+1)'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX)
                                                        : q_sum[DUTY_W-1:0];

   // State that reset clears
   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff <= '0;
         integ_ff    <= '0;
      end else begin
         if (cmd.err_en) begin
            last_err_ff <= err_in;
         end
         if (cmd.integ_en) begin
            integ_ff <= integ_in;
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         sum_ff <= sum_in;
      end
      if (cmd.mul_op != MUL_NONE) begin
         mul_ff <= mul_prod;
      end
      if (cmd.err_en) begin
         filt_ff <= filt_in;
         err_ff  <= err_in;
         diff_ff <= diff_in;
      end
      if (cmd.div_start) begin
         neg_ff <= neg_in;
      end
      if (cmd.dterm_en) begin
         dterm_ff <= term_in;
      end
      if (cmd.iterm_en) begin
         iterm_ff <= term_in;
      end
      if (cmd.s_en) begin
         s_ff <= s_in;
      end
      if (cmd.plo_en) begin
         plo_ff <= mul_ff[S_LO_W+GAIN_W-1:S_LO_W];
      end
      if (cmd.out_load) begin
         duty_ff     <= duty_in;
         rsp_filt_ff <= filt_ff;
         rsp_err_ff  <= err_ff;
      end
   end

   assign duty          = duty_ff;
   assign filtered      = rsp_filt_ff;
   assign control_error = rsp_err_ff;

endmodule

>>> hw/rtl/fpid_ctrl.sv
// Controller: sequences one item through the datapath and owns the handshakes.
// Depends on fpid_pkg.
module fpid_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  fpid_pkg::status_type status,
   output fpid_pkg::cmd_type    cmd
);
   import fpid_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      out_valid_ff;
   logic      out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.mul_op    = MUL_NONE;
      cmd.div_sel   = DIV_DTERM;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.shift = 1'b1;
               state_in  = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_FILT_MUL;
         end
         ST_FILT_MUL: begin
            cmd.mul_op = MUL_FILT;
            state_in   = ST_FILT;
         end
         ST_FILT: begin
            cmd.err_en = 1'b1;
            state_in   = ST_ERR_MUL;
         end
         ST_ERR_MUL: begin
            cmd.mul_op = MUL_ERR_PER;
            state_in   = ST_INTEG;
         end
         ST_INTEG: begin
            cmd.integ_en = 1'b1;
            cmd.mul_op   = MUL_TD_DIFF;
            state_in     = ST_DSCALE;
         end
         ST_DSCALE: begin
            cmd.mul_op = MUL_SCALE;
            state_in   = ST_DDIV;
         end
         ST_DDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_DTERM;
            cmd.mul_op    = MUL_TI;
            state_in      = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (!status.div_busy) begin
               cmd.dterm_en = 1'b1;
               state_in     = ST_IDIV;
            end
         end
         ST_IDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_ITERM;
            state_in      = ST_IWAIT;
         end
         ST_IWAIT: begin
            if (!status.div_busy) begin
               cmd.iterm_en = 1'b1;
               state_in     = ST_SSUM;
            end
         end
         ST_SSUM: begin
            cmd.s_en = 1'b1;
            state_in = ST_KLO;
         end
         ST_KLO: begin
            cmd.mul_op = MUL_KP_LO;
            state_in   = ST_KHI;
         end
         ST_KHI: begin
            cmd.plo_en = 1'b1;
            cmd.mul_op = MUL_KP_HI;
            state_in   = ST_DUTY;
         end
         ST_DUTY: begin
            // Hold until the output register is free or being emptied
            if (!out_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register valid: set on load, drop when taken
   always_comb begin
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

>>> hw/rtl/filtered_pid_duty_regulator.sv
// Filtered PID duty regulator, top level: register file, controller, datapath.
// A new sample is accepted only in idle, once the previous result is loaded into the output register.
// The throughput is set mainly by the shared divider, four quotient bits a cycle, run twice per item.
// The next sample is taken while the previous result still waits in the output register.
// Synchronous active-high reset clears the sample line, integral and last error, and loads the register defaults.
`include "filtered_pid_duty_regulator_assert.svh"

module filtered_pid_duty_regulator (
   input  logic                            clock,
   input  logic                            reset,
   fpid_req_if.sink                        req_chan,
   fpid_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fpid_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fpid_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [fpid_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import fpid_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   fpid_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fpid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   fpid_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd           (cmd),
      .status        (status),
      .sample        (req_chan.sample),
      .duty          (rsp_chan.duty),
      .filtered      (rsp_chan.filtered),
      .control_error (rsp_chan.control_error)
   );

   // Checks
   `FPID_ASSERT(a_duty_range, !rsp_chan.valid || (rsp_chan.duty <= DUTY_W'(DUTY_MAX)), "duty above limit")
   `FPID_ASSERT(a_err_consistent, !rsp_chan.valid || (rsp_chan.control_error == ($signed({1'b0, cfg.set_point}) - $signed({1'b0, rsp_chan.filtered}))), "error does not match set point and filtered level")
   `FPID_ASSERT(a_no_overwrite, !cmd.out_load || !rsp_chan.valid || rsp_chan.ready, "waiting result overwritten")
   `FPID_ASSERT_NEXT(a_div_launch, cmd.div_start && !status.div_busy, status.div_busy, "divider did not start")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the filtered PID duty regulator: sends samples, programs
// the registers over the APB-style port and checks every result against an in-bench model.
// Depends on fpid_pkg, fpid_req_if, fpid_rsp_if and the regulator RTL.
module tb_top;
   import fpid_pkg::*;

   localparam int     HALF_PERIOD    = 5;
   localparam int     RESET_CYCLES   = 10;
   localparam int     WATCHDOG_LIMIT = 1500;
   localparam int     DRAIN_CYCLES   = 60;
   localparam int     SETTLE_CYCLES  = 4;
   localparam int     REPORT_LIMIT   = 10;
   localparam int     RANDOM_PHASES  = 8;
   localparam int     PHASE_ITEMS    = 16;
   localparam int     SATURATION_CAP = 2400;
   localparam int     SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
   localparam int     GAIN_MAX       = (1 << GAIN_W) - 1;
   localparam int     PERIOD_MAX     = (1 << PERIOD_W) - 1;
   localparam int     INDEX_SLOTS    = 1 << $bits(reg_index_type);
   localparam longint ACC_MAX        = 64'sd2147483647;
   localparam longint ACC_MIN        = -64'sd2147483648;
   localparam longint TERM_LIMIT     = 64'sd1 << 40;
   localparam longint Q24_ONE        = 64'sd1 << 24;

   typedef struct packed {
      logic [DUTY_W-1:0]       duty;
      logic [SAMPLE_W-1:0]     filtered;
      logic signed [ERR_W-1:0] control_error;
   } duty_result_type;

   typedef enum int {
      SHAPE_UNIFORM,
      SHAPE_NEAR_TARGET,
      SHAPE_HELD,
      SHAPE_RAIL
   } sample_shape_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   fpid_req_if req_chan();
   fpid_rsp_if rsp_chan();

   // Model state: register copies, delay line, integral and last error
   cfg_type             cfg_shadow;
   logic [SAMPLE_W-1:0] tap_line [TAPS];
   int                  integral_sum;
   int                  last_err;

   duty_result_type pending_duties [$];
   int              mismatch_count = 0;
   int              idle_cycles = 0;
   int              burst_left = 0;
   int              stall_left = 0;
   int              pattern_age = 0;
   logic [15:0]     stall_pattern = 16'hFFFF;

   filtered_pid_duty_regulator u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // Bring the model to its state after reset
   function automatic void reset_model();
      int k;
      cfg_shadow.set_point       = '0;
      cfg_shadow.prop_gain       = 16'd256;
      cfg_shadow.integral_time   = 16'd256;
      cfg_shadow.derivative_time = '0;
      cfg_shadow.period_ms       = 8'd10;
      for (k = 0; k < TAPS; k++) tap_line[k] = '0;
      integral_sum = 0;
      last_err     = 0;
   endfunction

   // Shift one sample in and work out duty, filtered level and error
   function automatic duty_result_type compute_duty(input logic [SAMPLE_W-1:0] value);
      logic [SUM_W-1:0]    tap_total;
      logic [SAMPLE_W-1:0] level;
      longint              err, per, ti, acc, diff;
      longint              eterm, dterm, iterm, s, prod, q;
      duty_result_type     r;
      int                  k;
      for (k = TAPS - 1; k > 0; k--) tap_line[k] = tap_line[k - 1];
      tap_line[0] = value;
      tap_total = '0;
      for (k = 0; k < TAPS; k++) tap_total = tap_total + SUM_W'(tap_line[k]);
      level = SAMPLE_W'(tap_total / TAPS);

      err = longint'(cfg_shadow.set_point) - longint'(level);
      // a zero period or integral time counts as one
      per = (cfg_shadow.period_ms == 0) ? 64'sd1 : longint'(cfg_shadow.period_ms);
      ti  = (cfg_shadow.integral_time == 0) ? 64'sd1 : longint'(cfg_shadow.integral_time);

      // integral saturates at signed 32 bits
      acc = longint'(integral_sum) + err * per;
      if (acc > ACC_MAX) acc = ACC_MAX;
      if (acc < ACC_MIN) acc = ACC_MIN;
      integral_sum = int'(acc);

      diff     = err - longint'(last_err);
      last_err = int'(err);

      // terms in Q16, each truncated toward zero
      eterm = err * 65536;
      dterm = (longint'(cfg_shadow.derivative_time) * diff * 256000) / per;
      iterm = (acc * Q24_ONE) / (1000 * ti);
      s = eterm + dterm + iterm;
      if (s > TERM_LIMIT) s = TERM_LIMIT;
      if (s < -TERM_LIMIT) s = -TERM_LIMIT;

      // clamp the drive to the duty range
      prod = longint'(cfg_shadow.prop_gain) * s;
      if (prod <= 0) begin
         q = 0;
      end else begin
         q = prod / Q24_ONE;
         if (q > DUTY_MAX) q = DUTY_MAX;
      end

      r.duty          = q[DUTY_W-1:0];
      r.filtered      = level;
      r.control_error = err[ERR_W-1:0];
      return r;
   endfunction

   function automatic void note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%s", what);
   endfunction

   // Queue the expected result of every accepted sample
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         pending_duties.push_back(compute_duty(req_chan.sample));
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      duty_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_duties.size() == 0) begin
            note_mismatch($sformatf("result with nothing pending: duty=%0d filtered=%0d err=%0d",
               rsp_chan.duty, rsp_chan.filtered, $signed(rsp_chan.control_error)));
         end else begin
            want = pending_duties.pop_front();
            if (rsp_chan.duty !== want.duty || rsp_chan.filtered !== want.filtered ||
                rsp_chan.control_error !== want.control_error) begin
               note_mismatch($sformatf(
                  "mismatch: expected duty=%0d filtered=%0d err=%0d, got duty=%0d filtered=%0d err=%0d",
                  want.duty, want.filtered, $signed(want.control_error),
                  rsp_chan.duty, rsp_chan.filtered, $signed(rsp_chan.control_error)));
            end
         end
      end
   end

   // End the run when neither channel has moved an item for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: rotate a stall pattern, swap it now and then, add the odd long stall
   always @(negedge clock) begin
      logic take;
      if (pattern_age == 0) begin
         pattern_age = $urandom_range(64, 400);
         case ($urandom_range(0, 3))
            0:       stall_pattern = 16'hFFFF;
            1:       stall_pattern = 16'($urandom) | 16'h8421;
            default: stall_pattern = 16'($urandom) | 16'h0001;
         endcase
         if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(20, 120);
      end else begin
         pattern_age--;
      end
      if (stall_left > 0) begin
         stall_left--;
         take = 1'b0;
      end else begin
         take = stall_pattern[0];
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
      rsp_chan.ready <= take;
   end

   // Sender pacing: bursts of random length, random gaps, now and then a long stretch
   function automatic int next_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(40, 200);
      else burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 5) == 0) return $urandom_range(30, 80);
      return $urandom_range(1, 20);
   endfunction

   // Offer one sample, hold it until accepted, then idle if a gap is due
   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      int gap;
      req_chan.valid  <= 1'b1;
      req_chan.sample <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      gap = next_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Stop sending and wait until every pending result has come back
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      while (pending_duties.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // APB write: setup cycle, access cycle, then back to idle
   task automatic write_register(input logic [2:0] index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({index, 2'b00});
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (index)
         REG_SET_POINT:       cfg_shadow.set_point       = value[SAMPLE_W-1:0];
         REG_PROP_GAIN:       cfg_shadow.prop_gain       = value[GAIN_W-1:0];
         REG_INTEGRAL_TIME:   cfg_shadow.integral_time   = value[GAIN_W-1:0];
         REG_DERIVATIVE_TIME: cfg_shadow.derivative_time = value[GAIN_W-1:0];
         REG_PERIOD_MS:       cfg_shadow.period_ms       = value[PERIOD_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [31:0] sp, input logic [31:0] kp,
                                 input logic [31:0] ti, input logic [31:0] td,
                                 input logic [31:0] per);
      write_register(REG_SET_POINT, sp);
      write_register(REG_PROP_GAIN, kp);
      write_register(REG_INTEGRAL_TIME, ti);
      write_register(REG_DERIVATIVE_TIME, td);
      write_register(REG_PERIOD_MS, per);
   endtask

   // Random register value, weighted towards the ends of its range
   function automatic logic [31:0] pick_setting(input int lowest, input int top, input int modest);
      case ($urandom_range(0, 4))
         0:       return lowest;
         1:       return top;
         2:       return $urandom_range(lowest, modest);
         default: return $urandom_range(lowest, top);
      endcase
   endfunction

   // Samples straight after reset, with the reset settings
   task automatic check_reset_defaults();
      send_sample('0);
      send_sample(SAMPLE_W'(SAMPLE_MAX));
      send_sample(12'hAAA);
      send_sample(12'h555);
   endtask

   // Extreme settings, zero period and integral time, unused indexes, masked data
   task automatic check_extremes_and_specials();
      int idx;
      wait_for_results();
      // full gains with zero period and zero integral time: large drive, then negative
      apply_settings(SAMPLE_MAX, GAIN_MAX, 0, GAIN_MAX, 0);
      repeat (4) send_sample('0);
      repeat (4) send_sample(SAMPLE_W'(SAMPLE_MAX));
      wait_for_results();
      // writes to unused indexes change nothing; upper data bits are dropped
      for (idx = NUM_REGS; idx < INDEX_SLOTS; idx++) write_register(idx[2:0], '1);
      apply_settings(32'hFFFF_F800, 256, GAIN_MAX, 0, PERIOD_MAX);
      send_sample(SAMPLE_W'(SAMPLE_MAX));
      send_sample(12'hAAA);
      send_sample(12'h555);
      send_sample('0);
      wait_for_results();
      // smallest nonzero times and gains around the set point
      apply_settings(2048, 1, 1, 1, 1);
      send_sample(12'd2048);
      send_sample(12'd2049);
      send_sample(12'd2047);
      send_sample(12'd2048);
   endtask

   // Pin the integral at its upper limit, then pull it back off the limit
   task automatic check_integral_saturation();
      int n;
      wait_for_results();
      apply_settings(SAMPLE_MAX, 16, GAIN_MAX, 0, PERIOD_MAX);
      n = 0;
      while (integral_sum != int'(ACC_MAX) && n < SATURATION_CAP) begin
         send_sample('0);
         n++;
      end
      repeat (8) send_sample('0);
      wait_for_results();
      apply_settings(0, 16, GAIN_MAX, 0, PERIOD_MAX);
      repeat (8) send_sample(SAMPLE_W'(SAMPLE_MAX));
   endtask

   // Phases of random settings, each fed runs of shaped random samples
   task automatic check_random_settings();
      int                  phase, n, run_left, t;
      sample_shape_type    shape;
      logic [SAMPLE_W-1:0] value, held;
      shape = SHAPE_UNIFORM;
      held  = '0;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_results();
         if (phase == 0) begin
            apply_settings(SAMPLE_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, PERIOD_MAX);
         end else if (phase == 1) begin
            apply_settings(0, 0, 0, 0, 0);
         end else begin
            apply_settings(pick_setting(0, SAMPLE_MAX, SAMPLE_MAX),
                           pick_setting(0, GAIN_MAX, 1024),
                           pick_setting(0, GAIN_MAX, 2048),
                           pick_setting(0, GAIN_MAX, 64),
                           pick_setting(0, PERIOD_MAX, 20));
         end
         run_left = 0;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (run_left == 0) begin
               shape    = sample_shape_type'($urandom_range(0, 3));
               run_left = $urandom_range(5, 40);
               held     = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            end
            run_left--;
            case (shape)
               SHAPE_UNIFORM: value = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
               SHAPE_NEAR_TARGET: begin
                  t = int'(cfg_shadow.set_point) + int'($urandom_range(0, 600)) - 300;
                  if (t < 0) t = 0;
                  if (t > SAMPLE_MAX) t = SAMPLE_MAX;
                  value = t[SAMPLE_W-1:0];
               end
               SHAPE_HELD: value = held;
               default: value = $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
            endcase
            send_sample(value);
         end
      end
   endtask

   initial begin
      reset           = 1'b1;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      req_chan.valid  = 1'b0;
      req_chan.sample = '0;
      rsp_chan.ready  = 1'b0;
      reset_model();
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      check_reset_defaults();
      check_extremes_and_specials();
      check_integral_saturation();
      check_random_settings();

      // let the last results drain, then give stray ones a chance to show
      wait_for_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
